### sv/iof_pkg.sv
// ----------------------------------------------------------------------------
// iof_pkg
// Shared constants, controller states and the command/status bundles that
// pass between the interval overlap controller and its datapath.
// ----------------------------------------------------------------------------
package iof_pkg;

  // Default sizing of the range store
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int NUMBER_BITS_DEF  = 20;

  // Width of the reported load position
  localparam int SEG_IDX_W = 6;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;  // write the incoming range into the store
    logic start;  // begin a search run
    logic step;   // evaluate the current pair and advance
    logic flush;  // emit the closing result and end the run
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic stall;      // a hit cannot be taken this cycle
    logic last_pair;  // current pair is the final one of the run
    logic out_free;   // output register can take a transaction
  } sts_t;

endpackage

### sv/interval_overlap_finder_unit.sv
// ----------------------------------------------------------------------------
// interval_overlap_finder_unit
// Pairwise overlap search over one loaded list of ranges.
// ----------------------------------------------------------------------------
// Ranges load at one transaction per cycle into a store of MAX_SEGMENTS
// entries until a transaction marked last_segment arrives; extra entries
// are dropped and flagged on every result of the run. The search then walks
// every ordered pair (i outer, j inner) at one pair per cycle while the
// result side does not stall, using the two read ports of the store, and
// then closes the run with a final result.
// Input is held off during the search. Each overlapping entry is reported
// once in order of first discovery; the last result carries last_of_run, and
// a run with no overlap gives a single none_found result. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module interval_overlap_finder_unit #(
  parameter int MAX_SEGMENTS = iof_pkg::MAX_SEGMENTS_DEF,
  parameter int NUMBER_BITS  = iof_pkg::NUMBER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [NUMBER_BITS-1:0]        in_range_from,
  input  logic [NUMBER_BITS-1:0]        in_range_to,
  input  logic                          in_last_segment,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iof_pkg::SEG_IDX_W-1:0] out_segment_index,
  output logic [NUMBER_BITS-1:0]        out_seg_from,
  output logic [NUMBER_BITS-1:0]        out_seg_to,
  output logic                          out_none_found,
  output logic                          out_list_overflow,
  output logic                          out_last_of_run
);
  import iof_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  iof_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_segment (in_last_segment),
    .in_ready        (in_ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  // Store, compare and result path
  iof_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .NUMBER_BITS  (NUMBER_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_range_from     (in_range_from),
    .in_range_to       (in_range_to),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_segment_index (out_segment_index),
    .out_seg_from      (out_seg_from),
    .out_seg_to        (out_seg_to),
    .out_none_found    (out_none_found),
    .out_list_overflow (out_list_overflow),
    .out_last_of_run   (out_last_of_run)
  );

  // Search holds off input after the closing transaction of a list
  a_search_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_segment |=> !in_ready)
    else $error("input accepted right after list end");

  // An empty search result closes the run
  a_none_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |-> out_last_of_run)
    else $error("none_found result without last_of_run");

  // An empty search result carries zero fields
  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |->
      out_segment_index == '0 && out_seg_from == '0 && out_seg_to == '0)
    else $error("none_found result with nonzero fields");

endmodule

### sv/iof_ctrl.sv
// ----------------------------------------------------------------------------
// iof_ctrl
// Sequencer for the overlap search: load ranges, walk all pairs, then
// close the run with a final result.
// ----------------------------------------------------------------------------
module iof_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_segment,
  output logic          in_ready,
  input  iof_pkg::sts_t sts,
  output iof_pkg::cmd_t cmd
);
  import iof_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last_segment) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // hold the pair while a hit waits for the output register
        if (!sts.stall) begin
          cmd.step = 1'b1;
          if (sts.last_pair) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

### sv/iof_datapath.sv
// ----------------------------------------------------------------------------
// iof_datapath
// Range store with two read ports, pair counters, overlap compare,
// reported flags, one pending hit and the output register.
// ----------------------------------------------------------------------------
module iof_datapath #(
  parameter int MAX_SEGMENTS = iof_pkg::MAX_SEGMENTS_DEF,
  parameter int NUMBER_BITS  = iof_pkg::NUMBER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  iof_pkg::cmd_t                  cmd,
  output iof_pkg::sts_t                  sts,
  input  logic [NUMBER_BITS-1:0]         in_range_from,
  input  logic [NUMBER_BITS-1:0]         in_range_to,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [iof_pkg::SEG_IDX_W-1:0]  out_segment_index,
  output logic [NUMBER_BITS-1:0]         out_seg_from,
  output logic [NUMBER_BITS-1:0]         out_seg_to,
  output logic                           out_none_found,
  output logic                           out_list_overflow,
  output logic                           out_last_of_run
);
  import iof_pkg::*;

  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam int CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int EntW = 2 * NUMBER_BITS;

  // Range store: {from, to} per entry
  logic [EntW-1:0] store_mem [MAX_SEGMENTS];
  logic [EntW-1:0] rd_i_r;
  logic [EntW-1:0] rd_j_r;

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] cnt_m1;
  logic            ovf_r;
  logic            full;

  logic [IdxW-1:0] i_r;
  logic [IdxW-1:0] j_r;
  logic [IdxW-1:0] i_nxt;
  logic [IdxW-1:0] j_nxt;
  logic [IdxW-1:0] last_idx;

  logic [MAX_SEGMENTS-1:0] rep_r;

  logic                   pend_v_r;
  logic [IdxW-1:0]        pend_idx_r;
  logic [NUMBER_BITS-1:0] pend_from_r;
  logic [NUMBER_BITS-1:0] pend_to_r;

  logic                   out_valid_r;
  logic [SEG_IDX_W-1:0]   out_idx_r;
  logic [NUMBER_BITS-1:0] out_from_r;
  logic [NUMBER_BITS-1:0] out_to_r;
  logic                   out_none_r;
  logic                   out_ovf_r;
  logic                   out_last_r;

  logic [NUMBER_BITS-1:0] from_i;
  logic [NUMBER_BITS-1:0] to_i;
  logic [NUMBER_BITS-1:0] from_j;
  logic [NUMBER_BITS-1:0] to_j;
  logic                   hit;
  logic                   out_free;
  logic                   push_pend;

  assign full     = (count_r == CntW'(MAX_SEGMENTS));
  assign cnt_m1   = count_r - CntW'(1);
  assign last_idx = cnt_m1[IdxW-1:0];

  assign from_i = rd_i_r[EntW-1:NUMBER_BITS];
  assign to_i   = rd_i_r[NUMBER_BITS-1:0];
  assign from_j = rd_j_r[EntW-1:NUMBER_BITS];
  assign to_j   = rd_j_r[NUMBER_BITS-1:0];

  // Overlap test for the current pair, bounds inclusive
  assign hit = (i_r != j_r) && !rep_r[j_r] && (to_i >= from_j) && (from_i <= to_j);

  assign out_free  = !out_valid_r || out_ready;
  assign push_pend = cmd.step && hit && pend_v_r;

  assign sts.stall     = hit && pend_v_r && !out_free;
  assign sts.last_pair = (i_r == last_idx) && (j_r == last_idx);
  assign sts.out_free  = out_free;

  // Pair counters: j inner, i outer
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd.start) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.step) begin
      if (j_r == last_idx) begin
        j_nxt = '0;
        i_nxt = i_r + IdxW'(1);
      end else begin
        j_nxt = j_r + IdxW'(1);
      end
    end
  end

  // Store write and registered reads, addressed ahead so data tracks i and j
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      store_mem[count_r[IdxW-1:0]] <= {in_range_from, in_range_to};
    end
    rd_i_r <= store_mem[i_nxt];
    rd_j_r <= store_mem[j_nxt];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      rep_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;

      // load: append or drop when full
      if (cmd.store) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CntW'(1);
        end
      end

      if (cmd.start) begin
        rep_r <= '0;
      end else if (cmd.step && hit) begin
        rep_r[j_r] <= 1'b1;
      end

      if (cmd.step && hit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end

      if (cmd.flush) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end

      // output register handshake
      if (push_pend || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pending hit and output payload
  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_idx_r  <= j_r;
      pend_from_r <= from_j;
      pend_to_r   <= to_j;
    end
    if (push_pend) begin
      out_idx_r  <= SEG_IDX_W'(pend_idx_r);
      out_from_r <= pend_from_r;
      out_to_r   <= pend_to_r;
      out_none_r <= 1'b0;
      out_ovf_r  <= ovf_r;
      out_last_r <= 1'b0;
    end else if (cmd.flush) begin
      out_ovf_r  <= ovf_r;
      out_last_r <= 1'b1;
      if (pend_v_r) begin
        out_idx_r  <= SEG_IDX_W'(pend_idx_r);
        out_from_r <= pend_from_r;
        out_to_r   <= pend_to_r;
        out_none_r <= 1'b0;
      end else begin
        out_idx_r  <= '0;
        out_from_r <= '0;
        out_to_r   <= '0;
        out_none_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_index = out_idx_r;
  assign out_seg_from      = out_from_r;
  assign out_seg_to        = out_to_r;
  assign out_none_found    = out_none_r;
  assign out_list_overflow = out_ovf_r;
  assign out_last_of_run   = out_last_r;

endmodule
